// ===== rtl/zst_pkg.sv =====
// shared types and constants of the zhang-suen thinning pass
package zst_pkg;

    // configuration port
    localparam int CFG_DW = 11;
    localparam int CFG_AW = 2;

    localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PASS_SELECT  = 2'd2;

    // input word kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // reset sizes
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // one window column, bit 0 top row, bit 2 bottom row
    typedef logic [2:0] t_col;

    // one entry of the line store
    typedef struct packed {
        logic upper;
        logic middle;
    } t_lstore;

endpackage

// ===== rtl/zst_cell.sv =====
// one column cell of the 3x3 window chain
module zst_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_clear,
    input  zst_pkg::t_col i_col,
    output zst_pkg::t_col o_col
);
    import zst_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_clear) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// ===== rtl/zst_line_mem.sv =====
// two-row line store, one read and one write per cycle, registered read
module zst_line_mem #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  zst_pkg::t_lstore i_wdata,
    output zst_pkg::t_lstore o_rdata
);
    import zst_pkg::*;

    t_lstore r_mem [DEPTH];
    t_lstore r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-through on a same-address read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/zhang_suen_thinning_pass_top.sv =====
// top level of one zhang-suen thinning sub-iteration over a streamed binary frame
//
// pixels enter in raster order, one word per clock, and the block sustains one word
// per clock in both directions while m_axis_tready stays high. each result is the pixel
// frame_width + 1 words back, so after the last real pixel of a frame frame_width + 1
// flush words drain the tail; the word flagged by tlast closes the frame and the next
// word starts a new one. a word passes the line store read (a MAX_WIDTH x 2 bit memory,
// read and written once per word), registered alongside the second stage, then the
// window shift and the deletion decision, which land in the output register. the 3x3
// window is a chain of three column cells shifting once per word. border pixels pass
// unchanged and never report a deletion; line store contents left from an earlier frame
// only ever reach border decisions, so the store needs no clearing after reset. writing
// frame_width or frame_height aborts any frame in progress; pass_select applies at once
module zhang_suen_thinning_pass_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [zst_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [zst_pkg::CFG_DW-1:0] i_cfg_data,
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [0] pixel, [7:1] zero
    input  logic                       s_axis_tuser,   // [0] cmd
    // output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [0] pixel_out, [7:1] zero
    output logic                       m_axis_tuser,   // [0] deleted
    output logic                       m_axis_tlast    // last_pixel
);
    import zst_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);       // column index
    localparam int WW  = $clog2(MAX_WIDTH + 1);   // frame width value
    localparam int HW  = $clog2(MAX_HEIGHT + 1);  // frame height value
    localparam int IRW = $clog2(MAX_HEIGHT + 2);  // input row, runs to height + 1
    localparam int ORW = $clog2(MAX_HEIGHT);      // output row

    localparam int RST_W = (RESET_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  : RESET_WIDTH;
    localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    // clamp a written size into [3, maxv]
    function automatic int clamp_size(input logic [CFG_DW-1:0] v, input int maxv);
        int r;
        r = 32'(v);
        if (r < 3) begin
            r = 3;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    // neighbours in cyclic order n, ne, e, se, s, sw, w, nw
    function automatic logic deletable(input logic [7:0] nb, input logic sel);
        logic [3:0] fg;
        logic [3:0] trans;
        logic       prod;
        fg    = '0;
        trans = '0;
        for (int i = 0; i < 8; i++) begin
            fg = fg + 4'(nb[i]);
            if (!nb[i] && nb[(i + 1) % 8]) begin
                trans = trans + 4'd1;
            end
        end
        if (sel) begin
            prod = !(nb[0] && nb[2] && nb[6]) && !(nb[0] && nb[4] && nb[6]);
        end else begin
            prod = !(nb[0] && nb[2] && nb[4]) && !(nb[2] && nb[4] && nb[6]);
        end
        return (trans == 4'd1) && (fg >= 4'd2) && (fg <= 4'd6) && prod;
    endfunction

    // configuration
    logic [WW-1:0]  r_width;
    logic [HW-1:0]  r_height;
    logic           r_pass_sel;
    logic           size_write;

    // input side position
    logic [CW-1:0]  r_in_col;
    logic [IRW-1:0] r_in_row;

    // second stage
    logic           r_s1_valid;
    logic           r_s1_px;
    logic [CW-1:0]  r_s1_addr;
    logic           r_s1_emit;
    logic           r_s1_last;

    // output side position
    logic [CW-1:0]  r_out_col;
    logic [ORW-1:0] r_out_row;

    // output register
    logic           r_out_valid;
    logic           r_out_pix;
    logic           r_out_del;
    logic           r_out_last;

    logic           accept;
    logic           idle_flush;
    logic           px_eff;
    logic [CW:0]    col_inc;
    logic           col_wrap;
    logic [CW-1:0]  col_new;
    logic [IRW-1:0] row_new;
    logic           emit;
    logic           frame_end;
    logic           take;
    logic           out_free;
    logic           s1_fire;

    t_lstore        ls_rd;
    t_lstore        ls_wr;
    t_col           new_col;
    t_col           win_col [3];
    logic [7:0]     nbr;
    logic           center;
    logic           interior;
    logic           del;

    // ---------------------------------------------------------------- configuration
    assign size_write = i_cfg_we &&
                        ((i_cfg_addr == CFG_FRAME_WIDTH) || (i_cfg_addr == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(RST_W);
            r_height   <= HW'(RST_H);
            r_pass_sel <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_width    <= WW'(clamp_size(i_cfg_data, MAX_WIDTH));
                CFG_FRAME_HEIGHT: r_height   <= HW'(clamp_size(i_cfg_data, MAX_HEIGHT));
                CFG_PASS_SELECT:  r_pass_sel <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- input stage
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && (out_free || !r_s1_emit);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // a flush before the first pixel of a frame is swallowed
    assign idle_flush = (s_axis_tuser == CMD_FLUSH) && (r_in_row == '0) && (r_in_col == '0);
    assign take       = accept && !idle_flush;

    // flushes and words beyond the last row count as background
    assign px_eff = (s_axis_tuser == CMD_PIXEL) && (32'(r_in_row) < 32'(r_height)) &&
                    s_axis_tdata[0];

    assign col_inc  = {1'b0, r_in_col} + (CW+1)'(1);
    assign col_wrap = 32'(col_inc) >= 32'(r_width);
    assign col_new  = col_wrap ? '0 : col_inc[CW-1:0];
    assign row_new  = col_wrap ? r_in_row + IRW'(1) : r_in_row;

    // results start once the window centre reaches the first pixel
    assign emit = (row_new >= IRW'(2)) || ((row_new == IRW'(1)) && (col_new >= CW'(2)));

    // the word that yields the frame's final pixel sits at row height + 1, column 0
    assign frame_end = (32'(r_in_row) == 32'(r_height) + 1) && (r_in_col == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (size_write) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (take) begin
            if (frame_end) begin
                r_in_col <= '0;
                r_in_row <= '0;
            end else begin
                r_in_col <= col_new;
                r_in_row <= row_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_px   <= px_eff;
            r_s1_addr <= r_in_col;
            r_s1_emit <= emit;
            r_s1_last <= frame_end;
        end
    end

    // ---------------------------------------------------------------- line store
    // the stored middle row moves to the upper entry, the new pixel becomes the middle row
    assign ls_wr.upper  = ls_rd.middle;
    assign ls_wr.middle = r_s1_px;

    zst_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_re    (take),
        .i_raddr (r_in_col),
        .i_we    (s1_fire),
        .i_waddr (r_s1_addr),
        .i_wdata (ls_wr),
        .o_rdata (ls_rd)
    );

    // ---------------------------------------------------------------- window chain
    // newest column enters the right-hand cell and walks left
    assign new_col = {r_s1_px, ls_rd.middle, ls_rd.upper};

    for (genvar k = 0; k < 3; k++) begin : g_win
        zst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_fire),
            .i_clear (size_write || (s1_fire && r_s1_last)),
            .i_col   ((k == 2) ? new_col : win_col[(k + 1) % 3]),
            .o_col   (win_col[k])
        );
    end

    // decision on the window after this shift: left = cell 1, centre = cell 2, right = new
    assign center = win_col[2][1];
    assign nbr    = {win_col[1][0], win_col[1][1], win_col[1][2], win_col[2][2],
                     new_col[2], new_col[1], new_col[0], win_col[2][0]};

    assign interior = (r_out_row != '0) && (32'(r_out_row) + 1 < 32'(r_height)) &&
                      (r_out_col != '0) && (32'(r_out_col) + 1 < 32'(r_width));

    assign del = interior && center && deletable(nbr, r_pass_sel);

    // ---------------------------------------------------------------- output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (size_write) begin
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s1_fire && r_s1_emit) begin
            if (r_s1_last) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (32'(r_out_col) + 1 >= 32'(r_width)) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + ORW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out_pix  <= center && !del;
            r_out_del  <= del;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pix};
    assign m_axis_tuser  = r_out_del;
    assign m_axis_tlast  = r_out_last;

    // ---------------------------------------------------------------- checks
    // a deleted pixel always leaves as background
    a_del_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_del) |-> !r_out_pix)
        else $error("deleted pixel left as foreground");

    // the closing pixel is a corner and is never deleted
    a_last_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_out_del)
        else $error("deletion reported on the last pixel");

    // both column counters stay inside the frame
    a_in_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (32'(r_in_col) < 32'(r_width)))
        else $error("input column beyond frame width");

    a_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (32'(r_out_col) < 32'(r_width)))
        else $error("output column beyond frame width");

    // a result word is only produced by a stage-two word that was there
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_emit))
        else $error("result without a source word");

endmodule
